// File: design/mst_pkg.sv
// package for the multi-slot software timer
// command and status codes, shared limits and the structs passed between modules
// no dependencies
`default_nettype none

package mst_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int FIRE_CNT_W    = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] CMD_ADD     = 2'd0;
   localparam logic [1:0] CMD_REMOVE  = 2'd1;
   localparam logic [1:0] CMD_SERVICE = 2'd2;
   localparam logic [1:0] CMD_REARM   = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NO_SLOT    = 2'd1;
   localparam logic [1:0] ST_NO_HANDLER = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

   // one update of the slot table
   typedef struct packed {
      logic        ident_we;
      logic        deadline_we;
      logic        used_set;
      logic        used_clr;
      logic        rearm_set;
      logic        rearm_clr;
      logic [31:0] ident;
      logic [15:0] tag;
      logic [63:0] deadline;
   } slot_wr_type;

   // verdict of the compare unit on one slot
   typedef struct packed {
      logic hit;
      logic ok;
   } match_type;

endpackage

`default_nettype wire

// File: design/mst_channel_if.sv
// valid/ready channel interfaces for the multi-slot software timer
// request channel and response channel; no dependencies
`default_nettype none

interface mst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [63:0] time_now;
   logic [31:0] interval;
   logic [31:0] timer_id;
   logic        callback_valid;
   logic [15:0] tag;

   modport source (output valid, command, time_now, interval, timer_id, callback_valid, tag,
                   input ready);
   modport sink   (input valid, command, time_now, interval, timer_id, callback_valid, tag,
                   output ready);
endinterface

interface mst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] timer_id_res;
   logic [15:0] tag_res;
   logic        fired;
   logic        last;

   modport source (output valid, status, timer_id_res, tag_res, fired, last, input ready);
   modport sink   (input valid, status, timer_id_res, tag_res, fired, last, output ready);
endinterface

`default_nettype wire

// File: design/mst_slot_store.sv
// slot table of the multi-slot software timer
// identifier, tag and deadline memories with registered read, plus per-slot flag bits
// depends on mst_pkg
`default_nettype none

module mst_slot_store #(
   parameter int SLOTS = mst_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [IDX_W-1:0]     rd_addr,
   output logic [31:0]               rd_ident,
   output logic [15:0]               rd_tag,
   output logic [63:0]               rd_deadline,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire mst_pkg::slot_wr_type wr,
   output logic [SLOTS-1:0]          slot_used,
   output logic [SLOTS-1:0]          slot_rearm
);

   logic [31:0]      ident_mem_ff    [SLOTS];
   logic [15:0]      tag_mem_ff      [SLOTS];
   logic [63:0]      deadline_mem_ff [SLOTS];
   logic [31:0]      rd_ident_ff;
   logic [15:0]      rd_tag_ff;
   logic [63:0]      rd_deadline_ff;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] rearm_ff, rearm_in;

   // payload memories, no reset: entries are only read behind a set used bit
   always_ff @(posedge clock) begin
      if (wr.ident_we) begin
         ident_mem_ff[wr_addr] <= wr.ident;
         tag_mem_ff[wr_addr]   <= wr.tag;
      end
      if (wr.deadline_we) begin
         deadline_mem_ff[wr_addr] <= wr.deadline;
      end
      if (rd_en) begin
         rd_ident_ff    <= ident_mem_ff[rd_addr];
         rd_tag_ff      <= tag_mem_ff[rd_addr];
         rd_deadline_ff <= deadline_mem_ff[rd_addr];
      end
   end

   always_comb begin
      used_in  = used_ff;
      rearm_in = rearm_ff;
      if (wr.used_set)  used_in[wr_addr]  = 1'b1;
      if (wr.used_clr)  used_in[wr_addr]  = 1'b0;
      if (wr.rearm_set) rearm_in[wr_addr] = 1'b1;
      if (wr.rearm_clr) rearm_in[wr_addr] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         rearm_ff <= '0;
      end else begin
         used_ff  <= used_in;
         rearm_ff <= rearm_in;
      end
   end

   assign rd_ident    = rd_ident_ff;
   assign rd_tag      = rd_tag_ff;
   assign rd_deadline = rd_deadline_ff;
   assign slot_used   = used_ff;
   assign slot_rearm  = rearm_ff;

endmodule

`default_nettype wire

// File: design/mst_match_unit.sv
// shared compare unit of the multi-slot software timer
// judges one slot against the current command: id compare and deadline compare
// depends on mst_pkg
`default_nettype none

module mst_match_unit (
   input  wire logic [1:0]        cmd,
   input  wire logic [31:0]       timer_id,
   input  wire logic [63:0]       time_now,
   input  wire logic [31:0]       slot_ident,
   input  wire logic [63:0]       slot_deadline,
   input  wire logic              slot_used,
   input  wire logic              slot_rearm,
   output mst_pkg::match_type     verdict
);

   logic id_eq;
   logic due;

   assign id_eq = slot_used && (slot_ident == timer_id) && (timer_id != 32'd0);
   assign due   = slot_used && !slot_rearm && !(time_now < slot_deadline);

   always_comb begin
      verdict.ok = 1'b1;
      case (cmd)
         mst_pkg::CMD_ADD:     verdict.hit = !slot_used;
         mst_pkg::CMD_REMOVE:  verdict.hit = id_eq;
         mst_pkg::CMD_SERVICE: verdict.hit = due;
         mst_pkg::CMD_REARM: begin
            verdict.hit = id_eq;
            verdict.ok  = slot_rearm;
         end
         default:              verdict.hit = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// File: design/multi_slot_software_timer.sv
// multi-slot software timer, top level
// usage:
//   req_chan carries one command per transfer: add, remove, service or rearm.
//   rsp_chan returns the results; every command ends with a result that has
//   last set. a service returns one fired result per due slot (at most eight),
//   or a single empty result when nothing is due.
//   the sequencer walks the slot table one slot per cycle, unless frozen
//   as told below, through the shared compare unit; the slot memories have
//   a registered read, so the compare stage lags the read address by that register.
//   an add, remove or rearm stops the walk at the first matching slot; an add
//   without handler skips the walk and answers from the finish state.
//   only one command is handled at a time.
//   the request side is ready again while the last result still waits in the
//   output register.
//   a stalled receiver freezes the walk (read port and compare stage hold)
//   until the output register frees up; nothing is dropped.
//   reset: all slots free, no timer waiting for rearm, next identifier is one.
// depends on mst_pkg, mst_channel_if, mst_slot_store, mst_match_unit
`default_nettype none

module multi_slot_software_timer #(
   parameter int SLOTS = mst_pkg::SLOTS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mst_req_if.sink    req_chan,
   mst_rsp_if.source  rsp_chan
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int FCW   = mst_pkg::FIRE_CNT_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   // sequencer state
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;          // next slot to read
   logic             ev_v_ff, ev_v_in;        // compare stage holds a slot
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic [FCW-1:0]   nfire_ff, nfire_in;
   logic [31:0]      next_id_ff, next_id_in;

   // latched command
   logic [1:0]  cmd_ff, cmd_in;
   logic [63:0] now_ff, now_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] id_ff, id_in;
   logic [15:0] tag_ff, tag_in;
   logic        cb_ff, cb_in;
   logic        itv_zero_ff, itv_zero_in;

   // fired result held back until we know whether it is the last one
   logic        pend_v_ff, pend_v_in;
   logic [31:0] pend_id_ff, pend_id_in;
   logic [15:0] pend_tag_ff, pend_tag_in;

   // output register
   logic        out_v_ff, out_v_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [31:0] out_id_ff, out_id_in;
   logic [15:0] out_tag_ff, out_tag_in;
   logic        out_fired_ff, out_fired_in;
   logic        out_last_ff, out_last_in;

   logic                 out_free;
   logic                 rd_en;
   logic [31:0]          rd_ident;
   logic [15:0]          rd_tag;
   logic [63:0]          rd_deadline;
   logic [SLOTS-1:0]     slot_used;
   logic [SLOTS-1:0]     slot_rearm;
   mst_pkg::slot_wr_type wr;
   mst_pkg::match_type   verdict;
   logic                 proceed;

   mst_slot_store #(.SLOTS(SLOTS)) u_store (
      .clock       (clock),
      .reset       (reset),
      .rd_en       (rd_en),
      .rd_addr     (cnt_ff[IDX_W-1:0]),
      .rd_ident    (rd_ident),
      .rd_tag      (rd_tag),
      .rd_deadline (rd_deadline),
      .wr_addr     (ev_idx_ff),
      .wr          (wr),
      .slot_used   (slot_used),
      .slot_rearm  (slot_rearm)
   );

   mst_match_unit u_match (
      .cmd           (cmd_ff),
      .timer_id      (id_ff),
      .time_now      (now_ff),
      .slot_ident    (rd_ident),
      .slot_deadline (rd_deadline),
      .slot_used     (slot_used[ev_idx_ff]),
      .slot_rearm    (slot_rearm[ev_idx_ff]),
      .verdict       (verdict)
   );

   assign out_free       = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ev_v_in       = ev_v_ff;
      ev_idx_in     = ev_idx_ff;
      nfire_in      = nfire_ff;
      next_id_in    = next_id_ff;
      cmd_in        = cmd_ff;
      now_in        = now_ff;
      sum_in        = sum_ff;
      id_in         = id_ff;
      tag_in        = tag_ff;
      cb_in         = cb_ff;
      itv_zero_in   = itv_zero_ff;
      pend_v_in     = pend_v_ff;
      pend_id_in    = pend_id_ff;
      pend_tag_in   = pend_tag_ff;
      out_v_in      = out_v_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_id_in     = out_id_ff;
      out_tag_in    = out_tag_ff;
      out_fired_in  = out_fired_ff;
      out_last_in   = out_last_ff;
      rd_en         = 1'b0;
      proceed       = 1'b0;
      wr             = '0;
      wr.ident       = next_id_ff;
      wr.tag         = tag_ff;
      wr.deadline    = sum_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in      = req_chan.command;
               now_in      = req_chan.time_now;
               sum_in      = req_chan.time_now + 64'(req_chan.interval);
               id_in       = req_chan.timer_id;
               tag_in      = req_chan.tag;
               cb_in       = req_chan.callback_valid;
               itv_zero_in = (req_chan.interval == 32'd0);
               cnt_in      = '0;
               ev_v_in     = 1'b0;
               pend_v_in   = 1'b0;
               nfire_in    = '0;
               if (req_chan.command == mst_pkg::CMD_ADD && !req_chan.callback_valid) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (ev_v_ff && verdict.hit) begin
               if (cmd_ff != mst_pkg::CMD_SERVICE) begin
                  // first matching slot settles add, remove and rearm
                  if (out_free) begin
                     out_v_in      = 1'b1;
                     out_status_in = verdict.ok ? mst_pkg::ST_OK : mst_pkg::ST_NOT_FOUND;
                     out_id_in     = (cmd_ff == mst_pkg::CMD_ADD) ? next_id_ff : id_ff;
                     out_tag_in    = '0;
                     out_fired_in  = 1'b0;
                     out_last_in   = 1'b1;
                     state_in      = S_IDLE;
                     ev_v_in       = 1'b0;
                     case (cmd_ff)
                        mst_pkg::CMD_ADD: begin
                           wr.ident_we    = 1'b1;
                           wr.deadline_we = 1'b1;
                           wr.used_set    = 1'b1;
                           wr.rearm_clr   = 1'b1;
                           next_id_in     = (next_id_ff == 32'hFFFF_FFFF) ? 32'd1
                                                                          : next_id_ff + 32'd1;
                        end
                        mst_pkg::CMD_REMOVE: begin
                           wr.used_clr  = 1'b1;
                           wr.rearm_clr = 1'b1;
                        end
                        mst_pkg::CMD_REARM: begin
                           if (verdict.ok) begin
                              wr.rearm_clr   = 1'b1;
                              wr.used_clr    = itv_zero_ff;
                              wr.deadline_we = !itv_zero_ff;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end else if (!pend_v_ff || out_free) begin
                  // due slot: release the held result, hold this one
                  if (pend_v_ff) begin
                     out_v_in      = 1'b1;
                     out_status_in = mst_pkg::ST_OK;
                     out_id_in     = pend_id_ff;
                     out_tag_in    = pend_tag_ff;
                     out_fired_in  = 1'b1;
                     out_last_in   = 1'b0;
                  end
                  pend_v_in    = 1'b1;
                  pend_id_in   = rd_ident;
                  pend_tag_in  = rd_tag;
                  wr.rearm_set = 1'b1;
                  nfire_in     = nfire_ff + FCW'(1);
                  if (nfire_ff == FCW'(mst_pkg::MAX_RESULTS - 1)) begin
                     state_in = S_FINISH;
                     ev_v_in  = 1'b0;
                  end else begin
                     proceed = 1'b1;
                  end
               end
            end else begin
               proceed = 1'b1;
            end

            // advance the walk: read the next slot, move the read into compare
            if (proceed) begin
               if (cnt_ff < CNT_W'(SLOTS)) begin
                  rd_en     = 1'b1;
                  cnt_in    = cnt_ff + CNT_W'(1);
                  ev_v_in   = 1'b1;
                  ev_idx_in = cnt_ff[IDX_W-1:0];
               end else begin
                  ev_v_in = 1'b0;
                  if (!ev_v_ff) begin
                     state_in = S_FINISH;
                  end
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               out_v_in     = 1'b1;
               out_last_in  = 1'b1;
               out_tag_in   = '0;
               out_fired_in = 1'b0;
               state_in     = S_IDLE;
               case (cmd_ff)
                  mst_pkg::CMD_ADD: begin
                     out_status_in = cb_ff ? mst_pkg::ST_NO_SLOT : mst_pkg::ST_NO_HANDLER;
                     out_id_in     = '0;
                  end
                  mst_pkg::CMD_SERVICE: begin
                     out_status_in = mst_pkg::ST_OK;
                     out_id_in     = pend_v_ff ? pend_id_ff : 32'd0;
                     out_tag_in    = pend_v_ff ? pend_tag_ff : 16'd0;
                     out_fired_in  = pend_v_ff;
                     pend_v_in     = 1'b0;
                  end
                  default: begin
                     out_status_in = mst_pkg::ST_NOT_FOUND;
                     out_id_in     = id_ff;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         ev_v_ff    <= 1'b0;
         nfire_ff   <= '0;
         next_id_ff <= 32'd1;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         ev_v_ff    <= ev_v_in;
         nfire_ff   <= nfire_in;
         next_id_ff <= next_id_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_idx_ff     <= ev_idx_in;
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      sum_ff        <= sum_in;
      id_ff         <= id_in;
      tag_ff        <= tag_in;
      cb_ff         <= cb_in;
      itv_zero_ff   <= itv_zero_in;
      pend_id_ff    <= pend_id_in;
      pend_tag_ff   <= pend_tag_in;
      out_status_ff <= out_status_in;
      out_id_ff     <= out_id_in;
      out_tag_ff    <= out_tag_in;
      out_fired_ff  <= out_fired_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.timer_id_res = out_id_ff;
   assign rsp_chan.tag_res      = out_tag_ff;
   assign rsp_chan.fired        = out_fired_ff;
   assign rsp_chan.last         = out_last_ff;

endmodule

`default_nettype wire
